// ===== src/assert_macros.svh =====
// assertion macros shared by the rtl of the p25519 limb multiplier
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define MP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define MP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== src/mp25519_pkg.sv =====
// constants and types of the radix 2^51 multiplier modulo 2^255-19
// no dependencies; used by every module of the block
`default_nettype none

package mp25519_pkg;

   localparam int LIMB_BITS    = 51;
   localparam int LIMB_COUNT   = 5;
   localparam int Z1_BITS      = LIMB_BITS + 1;
   localparam int HALF_LO_BITS = (LIMB_BITS + 1) / 2;
   localparam int HALF_HI_BITS = LIMB_BITS - HALF_LO_BITS;
   localparam int PP_BITS      = 2 * HALF_LO_BITS;
   localparam int PROD_BITS    = 2 * LIMB_BITS;
   localparam int COLSUM_BITS  = PROD_BITS + 3;
   localparam int COL_BITS     = PROD_BITS + 8;
   localparam int CARRY_BITS   = COL_BITS - LIMB_BITS;
   localparam int FOLD_BITS    = CARRY_BITS + 5;
   localparam int REQ_BITS     = ((2 * LIMB_COUNT * LIMB_BITS + 7) / 8) * 8;
   localparam int RSP_BITS     = LIMB_COUNT * LIMB_BITS + 1;

   typedef logic [LIMB_BITS-1:0]                  limb_type;
   typedef limb_type [LIMB_COUNT-1:0]             limb_vec_type;
   typedef logic [PP_BITS-1:0]                    pp_type;
   typedef pp_type [LIMB_COUNT-1:0][LIMB_COUNT-1:0] pp_mat_type;
   typedef logic [PROD_BITS-1:0]                  prod_type;
   typedef prod_type [LIMB_COUNT-1:0][LIMB_COUNT-1:0] prod_mat_type;
   typedef logic [COLSUM_BITS-1:0]                colsum_type;
   typedef colsum_type [LIMB_COUNT-1:0]           colsum_vec_type;
   typedef logic [COL_BITS-1:0]                   col_type;
   typedef col_type [LIMB_COUNT-1:0]              col_vec_type;
   typedef logic [CARRY_BITS-1:0]                 carry_type;
   typedef logic [FOLD_BITS-1:0]                  fold_type;

endpackage

`default_nettype wire

// ===== src/mp25519_pp.sv =====
// partial products of all limb pairs, two register stages
// limbs split in halves so each multiplier stays near 26 x 26; uses mp25519_pkg
`default_nettype none

module mp25519_pp
   import mp25519_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  limb_vec_type x,
   input  limb_vec_type y,
   output logic         out_valid,
   output prod_mat_type prod
);

   logic         pp_valid_ff, prod_valid_ff;
   pp_mat_type   pp_ll_ff, pp_lh_ff, pp_hl_ff, pp_hh_ff;
   pp_mat_type   pp_ll_in, pp_lh_in, pp_hl_in, pp_hh_in;
   prod_mat_type prod_ff, prod_in;

   always_comb begin
      pp_type xl, xh, yl, yh;
      for (int j = 0; j < LIMB_COUNT; j++) begin
         for (int k = 0; k < LIMB_COUNT; k++) begin
            xl = pp_type'(x[j][HALF_LO_BITS-1:0]);
            xh = pp_type'(x[j][LIMB_BITS-1:HALF_LO_BITS]);
            yl = pp_type'(y[k][HALF_LO_BITS-1:0]);
            yh = pp_type'(y[k][LIMB_BITS-1:HALF_LO_BITS]);
            pp_ll_in[j][k] = xl * yl;
            pp_lh_in[j][k] = xl * yh;
            pp_hl_in[j][k] = xh * yl;
            pp_hh_in[j][k] = xh * yh;
         end
      end
   end

   // recombine the four quarters into the full 102-bit product
   always_comb begin
      for (int j = 0; j < LIMB_COUNT; j++) begin
         for (int k = 0; k < LIMB_COUNT; k++) begin
            prod_in[j][k] = prod_type'(pp_ll_ff[j][k])
               + ((prod_type'(pp_lh_ff[j][k]) + prod_type'(pp_hl_ff[j][k])) << HALF_LO_BITS)
               + (prod_type'(pp_hh_ff[j][k]) << (2 * HALF_LO_BITS));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else if (en) begin
         pp_valid_ff   <= in_valid;
         prod_valid_ff <= pp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ll_ff <= pp_ll_in;
         pp_lh_ff <= pp_lh_in;
         pp_hl_ff <= pp_hl_in;
         pp_hh_ff <= pp_hh_in;
         prod_ff  <= prod_in;
      end
   end

   assign out_valid = prod_valid_ff;
   assign prod      = prod_ff;

endmodule

`default_nettype wire

// ===== src/mp25519_col.sv =====
// column sums of the limb products with wrapped terms folded times 19
// two register stages; uses mp25519_pkg
`default_nettype none

module mp25519_col
   import mp25519_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  prod_mat_type prod,
   output logic         out_valid,
   output col_vec_type  col
);

   logic           sum_valid_ff, col_valid_ff;
   colsum_vec_type lo_ff, lo_in, hi_ff, hi_in;
   col_vec_type    col_ff, col_in;

   // column i: x[j]*y[i-j] for j <= i, wrapped x[j]*y[n+i-j] for j > i
   always_comb begin
      for (int i = 0; i < LIMB_COUNT; i++) begin
         lo_in[i] = '0;
         hi_in[i] = '0;
         for (int j = 0; j < LIMB_COUNT; j++) begin
            if (j <= i) begin
               lo_in[i] = lo_in[i] + colsum_type'(prod[j][i-j]);
            end else begin
               hi_in[i] = hi_in[i] + colsum_type'(prod[j][LIMB_COUNT+i-j]);
            end
         end
      end
   end

   // times 19 as 16 + 2 + 1
   always_comb begin
      for (int i = 0; i < LIMB_COUNT; i++) begin
         col_in[i] = col_type'(lo_ff[i]) + (col_type'(hi_ff[i]) << 4)
            + (col_type'(hi_ff[i]) << 1) + col_type'(hi_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
         col_valid_ff <= 1'b0;
      end else if (en) begin
         sum_valid_ff <= in_valid;
         col_valid_ff <= sum_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
         col_ff <= col_in;
      end
   end

   assign out_valid = col_valid_ff;
   assign col       = col_ff;

endmodule

`default_nettype wire

// ===== src/mp25519_carry.sv =====
// carry chain over the columns, one column per stage, then the final
// carry scaled by 19 in a stage of its own; uses mp25519_pkg
`default_nettype none

module mp25519_carry
   import mp25519_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  col_vec_type  col,
   output logic         out_valid,
   output limb_vec_type digit,
   output fold_type     fold
);

   logic [LIMB_COUNT-1:0] stg_valid_ff, stg_valid_in;
   col_vec_type           stg_col_ff [LIMB_COUNT];
   col_vec_type           stg_col_in [LIMB_COUNT];
   carry_type             stg_carry_ff [LIMB_COUNT];
   carry_type             stg_carry_in [LIMB_COUNT];
   limb_vec_type          stg_digit_ff [LIMB_COUNT];
   limb_vec_type          stg_digit_in [LIMB_COUNT];
   logic                  fold_valid_ff;
   fold_type              fold_ff, fold_in;
   limb_vec_type          fold_digit_ff;
   fold_type              last_carry;

   // stage s settles column s and hands its carry on
   always_comb begin
      logic         valid_src;
      col_vec_type  col_src;
      carry_type    carry_src;
      limb_vec_type digit_src;
      col_type      sum;
      for (int s = 0; s < LIMB_COUNT; s++) begin
         if (s == 0) begin
            valid_src = in_valid;
            col_src   = col;
            carry_src = '0;
            digit_src = '0;
         end else begin
            valid_src = stg_valid_ff[s-1];
            col_src   = stg_col_ff[s-1];
            carry_src = stg_carry_ff[s-1];
            digit_src = stg_digit_ff[s-1];
         end
         sum                = col_src[s] + col_type'(carry_src);
         stg_valid_in[s]    = valid_src;
         stg_col_in[s]      = col_src;
         stg_carry_in[s]    = carry_type'(sum >> LIMB_BITS);
         stg_digit_in[s]    = digit_src;
         stg_digit_in[s][s] = sum[LIMB_BITS-1:0];
      end
   end

   // 2^255 = 19 mod p, so the carry past the top limb comes back times 19
   assign last_carry = fold_type'(stg_carry_ff[LIMB_COUNT-1]);
   assign fold_in    = (last_carry << 4) + (last_carry << 1) + last_carry;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff  <= '0;
         fold_valid_ff <= 1'b0;
      end else if (en) begin
         stg_valid_ff  <= stg_valid_in;
         fold_valid_ff <= stg_valid_ff[LIMB_COUNT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < LIMB_COUNT; s++) begin
            stg_col_ff[s]   <= stg_col_in[s];
            stg_carry_ff[s] <= stg_carry_in[s];
            stg_digit_ff[s] <= stg_digit_in[s];
         end
         fold_ff       <= fold_in;
         fold_digit_ff <= stg_digit_ff[LIMB_COUNT-1];
      end
   end

   assign out_valid = fold_valid_ff;
   assign digit     = fold_digit_ff;
   assign fold      = fold_ff;

endmodule

`default_nettype wire

// ===== src/mod_p25519_limb_multiplier.sv =====
// Multiplier modulo 2^255-19 over five 51-bit limbs, partially reduced result.
// req_* carries one pair of operands per word, rsp_* one product per word.
// Both channels use tvalid/tready; a word moves on an edge where both are high.
// From acceptance to rsp_tvalid a word passes 2 stages of split partial
// products, 2 of column sums and the times-19 fold, 5 for the carry chain
// (one column each), 1 to scale the final carry, 1 output register. When
// not stalled, throughput is one word per cycle: every stage is a plain
// register, the carry chain sets the stage count. The result register sits
// at the end of the pipe; when the receiver holds rsp_tready low while a
// result waits, the whole pipe freezes and req_tready drops, nothing is
// lost or repeated. Reset (synchronous, active high) clears all valid bits;
// no data state. Limb 1 of the result may carry one bit above 51.
// Depends on mp25519_pkg, mp25519_pp, mp25519_col, mp25519_carry and
// assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mod_p25519_limb_multiplier
   import mp25519_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // x_limb0..x_limb4, y_limb0..y_limb4, 51 bits each, two zero bits on top
   input  logic [REQ_BITS-1:0] req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // z_limb0 (51), z_limb1 (52), z_limb2, z_limb3, z_limb4 (51 each)
   output logic [RSP_BITS-1:0] rsp_tdata
);

   logic                pipe_en;
   limb_vec_type        x_limb, y_limb;
   logic                prod_valid, col_valid, fold_valid;
   prod_mat_type        prod;
   col_vec_type         col;
   limb_vec_type        digit;
   fold_type            fold_val;
   logic [Z1_BITS-1:0]  sum0;
   logic [Z1_BITS-1:0]  carry1;
   logic [Z1_BITS-1:0]  z_limb1;
   logic                rsp_valid_ff;
   logic [RSP_BITS-1:0] rsp_data_ff, rsp_data_in;

   assign pipe_en    = !rsp_valid_ff || rsp_tready;
   assign req_tready = pipe_en;

   always_comb begin
      for (int k = 0; k < LIMB_COUNT; k++) begin
         x_limb[k] = req_tdata[k*LIMB_BITS +: LIMB_BITS];
         y_limb[k] = req_tdata[(LIMB_COUNT+k)*LIMB_BITS +: LIMB_BITS];
      end
   end

   mp25519_pp u_pp (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (req_tvalid),
      .x         (x_limb),
      .y         (y_limb),
      .out_valid (prod_valid),
      .prod      (prod)
   );

   mp25519_col u_col (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (prod_valid),
      .prod      (prod),
      .out_valid (col_valid),
      .col       (col)
   );

   mp25519_carry u_carry (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (col_valid),
      .col       (col),
      .out_valid (fold_valid),
      .digit     (digit),
      .fold      (fold_val)
   );

   // add the folded carry into limb 0, its overflow goes to limb 1
   assign sum0    = {1'b0, digit[0]} + {1'b0, fold_val[LIMB_BITS-1:0]};
   assign carry1  = Z1_BITS'(fold_val[FOLD_BITS-1:LIMB_BITS]) + Z1_BITS'(sum0[LIMB_BITS]);
   assign z_limb1 = {1'b0, digit[1]} + carry1;

   assign rsp_data_in = {digit[4], digit[3], digit[2], z_limb1, sum0[LIMB_BITS-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= fold_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // final carry is below 2^54, so 19 times it never reaches bit 59
   `MP_ASSERT_IMPLY(a_fold_range, clock, reset, fold_valid, fold_val[FOLD_BITS-1:FOLD_BITS-5] == '0, "folded carry out of range")
   `MP_ASSERT_NEXT(a_pipe_frozen, clock, reset, !pipe_en, $stable(fold_valid) && $stable(fold_val), "pipe moved while stalled")
   `MP_ASSERT_IMPLY(a_rsp_source, clock, reset, $rose(rsp_tvalid), $past(fold_valid), "result word without a pipe word")

endmodule

`default_nettype wire

// ===== verif/mod_p25519_limb_multiplier_test.sv =====
// self-checking bench for the radix 2^51 multiplier modulo 2^255-19
// drives operand words, predicts each product and compares it limb by limb
// depends on mp25519_pkg and the rtl of mod_p25519_limb_multiplier
module mod_p25519_limb_multiplier_test;
   timeunit 1ns;
   timeprecision 1ps;
   import mp25519_pkg::*;

   localparam int unsigned FOLD_FACTOR = 19;
   localparam int PIPE_DEPTH = 11;
   localparam int ITEMS_PER_PHASE = 450;

   // z_limb4 sits in the top bits, z_limb0 in the lowest
   typedef struct packed {
      limb_type               z4;
      limb_type               z3;
      limb_type               z2;
      logic [Z1_BITS-1:0]     z1;
      limb_type               z0;
   } product_word_type;

   class product_board;
      product_word_type expected_q[$];
      int failures;

      function new();
         failures = 0;
      endfunction

      // column sums with the high wrapped terms folded in times 19
      function product_word_type multiply_mod(limb_vec_type x, limb_vec_type y);
         logic [127:0] acc;
         logic [63:0] v[LIMB_COUNT];
         logic [63:0] sum;
         logic [63:0] carry;
         product_word_type p;
         acc = '0;
         for (int i = 0; i < LIMB_COUNT; i++) begin
            for (int j = i + 1; j < LIMB_COUNT; j++) begin
               acc = acc + 128'(x[j]) * 128'(y[LIMB_COUNT - j + i]) * 128'(FOLD_FACTOR);
            end
            for (int j = 0; j <= i; j++) begin
               acc = acc + 128'(x[j]) * 128'(y[i - j]);
            end
            v[i] = 64'(acc[LIMB_BITS-1:0]);
            acc = acc >> LIMB_BITS;
         end
         // final carry goes back into limb 0, its overflow into limb 1
         acc = acc * 128'(FOLD_FACTOR);
         sum = v[0] + 64'(acc[LIMB_BITS-1:0]);
         carry = (sum >> LIMB_BITS) + 64'(acc >> LIMB_BITS);
         p.z0 = limb_type'(sum);
         p.z1 = Z1_BITS'(v[1] + carry);
         p.z2 = limb_type'(v[2]);
         p.z3 = limb_type'(v[3]);
         p.z4 = limb_type'(v[4]);
         return p;
      endfunction

      function void note_operands(limb_vec_type x, limb_vec_type y);
         expected_q.push_back(multiply_mod(x, y));
      endfunction

      function void compare_limb(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            failures++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         end
      endfunction

      function void check_product(product_word_type got);
         product_word_type want;
         if (expected_q.size() == 0) begin
            failures++;
            $display("%0t: product word with nothing expected, expected none actual %h",
                     $time, got);
            return;
         end
         want = expected_q.pop_front();
         compare_limb("z_limb0", 64'(want.z0), 64'(got.z0));
         compare_limb("z_limb1", 64'(want.z1), 64'(got.z1));
         compare_limb("z_limb2", 64'(want.z2), 64'(got.z2));
         compare_limb("z_limb3", 64'(want.z3), 64'(got.z3));
         compare_limb("z_limb4", 64'(want.z4), 64'(got.z4));
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [REQ_BITS-1:0] req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_BITS-1:0] rsp_tdata;

   int send_idle = 0;
   int recv_idle = 0;
   int send_pct[3] = '{34, 65, 0};
   int recv_pct[3] = '{65, 34, 0};

   product_board board = new();

   mod_p25519_limb_multiplier dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // result side: sample the word at the edge, then pick the next tready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_product(product_word_type'(rsp_tdata));
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   function automatic limb_type random_limb();
      limb_type v;
      int unsigned mode;
      mode = $urandom_range(9);
      v = limb_type'({$urandom, $urandom});
      case (mode)
         0: v = '0;
         1: v = '1;
         2: v = limb_type'($urandom_range(255));
         3: v = '1 - limb_type'($urandom_range(255));
         4: v = limb_type'(1) << $urandom_range(LIMB_BITS - 1);
         default: ;
      endcase
      return v;
   endfunction

   function automatic limb_vec_type fill_limbs(limb_type v);
      limb_vec_type r;
      for (int k = 0; k < LIMB_COUNT; k++) r[k] = v;
      return r;
   endfunction

   task automatic send_operands(input limb_vec_type x, input limb_vec_type y);
      if (send_idle != 0 && $urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_BITS'({y, x});
      do @(posedge clock); while (!req_tready);
      board.note_operands(x, y);
   endtask

   task automatic send_directed();
      limb_vec_type zero, full, one, p_vec, top, top_bit, alt, alt_inv;
      zero = '0;
      full = fill_limbs('1);
      one = '0;
      one[0] = limb_type'(1);
      p_vec = full;
      p_vec[0] = '1 - limb_type'(FOLD_FACTOR - 1);
      top = '0;
      top[LIMB_COUNT-1] = '1;
      top_bit = '0;
      top_bit[LIMB_COUNT-1] = limb_type'(1) << (LIMB_BITS - 1);
      alt = fill_limbs(limb_type'({26{2'b01}}));
      alt_inv = ~alt;
      send_operands(zero, zero);
      send_operands(full, full);
      send_operands(full, zero);
      send_operands(zero, full);
      send_operands(one, one);
      send_operands(full, one);
      send_operands(one, full);
      send_operands(p_vec, p_vec);
      send_operands(p_vec, full);
      send_operands(top, top);
      send_operands(top, full);
      send_operands(top_bit, top_bit);
      send_operands(alt, alt);
      send_operands(alt, alt_inv);
      send_operands(alt_inv, full);
      send_operands(fill_limbs(limb_type'(1) << (LIMB_BITS - 1)), full);
   endtask

   task automatic send_random(input int count);
      limb_vec_type x, y;
      for (int n = 0; n < count; n++) begin
         for (int k = 0; k < LIMB_COUNT; k++) begin
            x[k] = random_limb();
            y[k] = random_limb();
         end
         // widest column sums now and then
         if ($urandom_range(19) == 0) begin
            x = fill_limbs('1);
            y = fill_limbs('1) ^ limb_vec_type'($urandom_range(255));
         end
         send_operands(x, y);
      end
   endtask

   task automatic drain_products();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int phase = 0; phase < 3; phase++) begin
         send_idle = send_pct[phase];
         recv_idle = recv_pct[phase];
         if (phase == 0) send_directed();
         send_random(ITEMS_PER_PHASE);
         // hold off until the pipe has delivered everything
         drain_products();
      end
      repeat (2 * PIPE_DEPTH) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
